// File: sv/gcet_pkg.sv
// Shared widths, register indexes and field codes of the graph-cut energy term generator.
`default_nettype none

package gcet_pkg;

    localparam int PIXEL_W    = 8;
    localparam int DIM_W      = 9;
    localparam int ID_W       = 16;
    localparam int SRC_W      = 9;
    localparam int EW_W       = 16;
    localparam int GAIN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRUNCATION_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GAIN      = 3'd4;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    localparam logic KIND_UNARY = 1'b0;
    localparam logic KIND_EDGE  = 1'b1;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [ID_W-1:0]    node_id_t;
    typedef logic signed [SRC_W-1:0] src_weight_t;
    typedef logic [EW_W-1:0]    edge_weight_t;

endpackage

`default_nettype wire

// File: sv/gcet_pixel_if.sv
// Input channel carrying one pixel or drain transaction.
`default_nettype none

interface gcet_pixel_if;
    import gcet_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    pixel_t pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink (input valid, input mode, input pixel, output ready);
endinterface

`default_nettype wire

// File: sv/gcet_term_if.sv
// Output channel carrying one energy term transaction.
`default_nettype none

interface gcet_term_if;
    import gcet_pkg::*;

    logic         valid;
    logic         ready;
    logic         kind;
    node_id_t     node_id;
    node_id_t     neighbour_id;
    src_weight_t  source_weight;
    pixel_t       sink_weight;
    edge_weight_t edge_weight;
    logic         last_of_center;

    modport source (output valid, output kind, output node_id, output neighbour_id,
                    output source_weight, output sink_weight, output edge_weight,
                    output last_of_center, input ready);
    modport sink (input valid, input kind, input node_id, input neighbour_id,
                  input source_weight, input sink_weight, input edge_weight,
                  input last_of_center, output ready);
endinterface

`default_nettype wire

// File: sv/gcet_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module gcet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 514
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/graph_cut_energy_terms.sv
// Top level of the graph-cut energy term generator with its window store and term sequencer.
// An item that releases no center only updates the window store and counters; one that releases
// a center emits its unary term, then one edge term per in-frame neighbour, read through the single
// read port of the window store, with each edge weight formed by a two-step multiply. A write to
// frame_width holds off input until the column and row have been recomputed.
// Reset zeroes the counters and returns the configuration to its defaults; the window store is left uncleared.
`default_nettype none

module graph_cut_energy_terms #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    gcet_pixel_if.sink                         pix_stream,
    gcet_term_if.source                        term_stream,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gcet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcet_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import gcet_pkg::*;

    localparam int STORE_DEPTH = 2 * MAX_WIDTH + 2;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CMP_W       = CNT_W + 2;
    localparam int SUM_W       = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 2;
    localparam int DIVC_W      = $clog2(CNT_W + 1);
    localparam int PROD_W      = 2 * PIXEL_W + GAIN_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CRD  = 8'b0000_0010,
        S_CLAT = 8'b0000_0100,
        S_NEXT = 8'b0000_1000,
        S_NLAT = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_EMIT = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    // Configuration registers.
    dim_t                frame_width_reg;
    dim_t                frame_height_reg;
    pixel_t              full_scale_reg;
    logic [EW_W-1:0]     trunc_limit_reg;
    logic [GAIN_W-1:0]   smooth_gain_reg;

    // Sequencer and counters.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    rc_reg, rc_next;
    logic [CNT_W-1:0]    c_reg, c_next;
    logic [SLOT_W-1:0]   wslot_reg, wslot_next;
    logic [SLOT_W-1:0]   cslot_reg, cslot_next;
    dim_t                col_reg, col_next;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic                has_new_reg, has_new_next;
    logic                ready_reg, ready_next;
    logic [2:0]          k_reg, k_next;
    logic [7:0]          mask_reg, mask_next;
    logic                last_reg, last_next;
    logic                unary_reg, unary_next;
    logic                fwd_reg, fwd_next;
    logic [DIVC_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers.
    pixel_t              pix_reg, pix_next;
    pixel_t              cv_reg, cv_next;
    logic [CNT_W-1:0]    ni_reg, ni_next;
    logic [2*PIXEL_W-1:0] sq_reg, sq_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [DIM_W:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]    quo_reg, quo_next;
    logic                out_kind_reg, out_kind_next;
    node_id_t            out_node_reg, out_node_next;
    node_id_t            out_nbr_reg, out_nbr_next;
    src_weight_t         out_src_reg, out_src_next;
    pixel_t              out_snk_reg, out_snk_next;
    edge_weight_t        out_ew_reg, out_ew_next;
    logic                out_last_reg, out_last_next;

    // Combinational helpers.
    dim_t                w_eff, h_eff;
    logic [2*DIM_W-1:0]  dims_prod;
    logic [CNT_W-1:0]    total;
    logic [CMP_W-1:0]    avail, reach;
    logic                acc_has_new, acc_ready;
    logic                up_ok, down_ok, left_ok, right_ok;
    logic [7:0]          mask_comb;
    logic signed [SUM_W-1:0] w_s, off, c_s, cslot_s, ni_s, slot_s, slot_fix;
    logic [SLOT_W-1:0]   nslot, rd_addr;
    logic [CNT_W-1:0]    ni;
    pixel_t              rd_data, nv, d;
    logic [PROD_W-5:0]   ew_full;
    edge_weight_t        ew_clamped;
    logic                out_free;
    logic [DIM_W:0]      trial;
    logic                qbit;
    logic [DIM_W:0]      col_inc;
    logic [SLOT_W:0]     wslot_inc, cslot_inc;
    logic                mem_we;
    logic                in_ready;

    assign w_eff = (frame_width_reg == '0) ? DIM_W'(1)
                 : (32'(frame_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : frame_width_reg;
    assign h_eff = (frame_height_reg == '0) ? DIM_W'(1)
                 : (32'(frame_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : frame_height_reg;
    assign dims_prod = w_eff * h_eff;
    assign total     = CNT_W'(dims_prod);

    assign acc_has_new = (pix_stream.mode == MODE_PIXEL) && (rc_reg < total);
    assign avail       = CMP_W'(rc_reg) + CMP_W'(acc_has_new);
    assign reach       = CMP_W'(c_reg) + CMP_W'(w_eff) + CMP_W'(1);
    assign acc_ready   = (c_reg < total) && ((avail >= CMP_W'(total)) || (avail > reach));

    assign up_ok    = (row_reg != '0);
    assign down_ok  = (CMP_W'(row_reg) + CMP_W'(1)) < CMP_W'(h_eff);
    assign left_ok  = (col_reg != '0);
    assign right_ok = ((DIM_W + 1)'(col_reg) + (DIM_W + 1)'(1)) < (DIM_W + 1)'(w_eff);
    assign mask_comb = {down_ok & right_ok, down_ok, down_ok & left_ok, right_ok,
                        left_ok, up_ok & right_ok, up_ok, up_ok & left_ok};

    assign w_s     = $signed(SUM_W'(w_eff));
    assign c_s     = $signed(SUM_W'(c_reg));
    assign cslot_s = $signed(SUM_W'(cslot_reg));

    always_comb
    begin
        case (k_reg)
            3'd0:    off = -w_s - $signed(SUM_W'(1));
            3'd1:    off = -w_s;
            3'd2:    off = -w_s + $signed(SUM_W'(1));
            3'd3:    off = -$signed(SUM_W'(1));
            3'd4:    off = $signed(SUM_W'(1));
            3'd5:    off = w_s - $signed(SUM_W'(1));
            3'd6:    off = w_s;
            default: off = w_s + $signed(SUM_W'(1));
        endcase
    end

    assign ni_s   = c_s + off;
    assign ni     = ni_s[CNT_W-1:0];
    assign slot_s = cslot_s + off;

    always_comb
    begin
        if (slot_s < 0)
        begin
            slot_fix = slot_s + $signed(SUM_W'(STORE_DEPTH));
        end
        else if (slot_s >= $signed(SUM_W'(STORE_DEPTH)))
        begin
            slot_fix = slot_s - $signed(SUM_W'(STORE_DEPTH));
        end
        else
        begin
            slot_fix = slot_s;
        end
    end

    assign nslot   = slot_fix[SLOT_W-1:0];
    assign rd_addr = (state_reg == S_CRD) ? cslot_reg : nslot;
    assign mem_we  = (state_reg == S_FIN) && has_new_reg;

    gcet_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_window_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wslot_reg),
        .wr_data (pix_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign nv = fwd_reg ? pix_reg : rd_data;
    assign d  = (nv > cv_reg) ? (nv - cv_reg) : (cv_reg - nv);

    assign ew_full    = prod_reg[PROD_W-1:4];
    assign ew_clamped = (ew_full > (PROD_W - 4)'(trunc_limit_reg)) ? trunc_limit_reg
                                                                    : EW_W'(ew_full);

    assign out_free = !out_valid_reg || term_stream.ready;
    assign in_ready = (state_reg == S_IDLE) && (div_cnt_reg == '0);

    assign trial = {rem_reg[DIM_W-1:0], quo_reg[CNT_W-1]};
    assign qbit  = (trial >= (DIM_W + 1)'(w_eff));

    assign col_inc   = (DIM_W + 1)'(col_reg) + (DIM_W + 1)'(1);
    assign wslot_inc = (SLOT_W + 1)'(wslot_reg) + (SLOT_W + 1)'(1);
    assign cslot_inc = (SLOT_W + 1)'(cslot_reg) + (SLOT_W + 1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        rc_next        = rc_reg;
        c_next         = c_reg;
        wslot_next     = wslot_reg;
        cslot_next     = cslot_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        has_new_next   = has_new_reg;
        ready_next     = ready_reg;
        k_next         = k_reg;
        mask_next      = mask_reg;
        last_next      = last_reg;
        unary_next     = unary_reg;
        fwd_next       = fwd_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !term_stream.ready;
        pix_next       = pix_reg;
        cv_next        = cv_reg;
        ni_next        = ni_reg;
        sq_next        = sq_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_kind_next  = out_kind_reg;
        out_node_next  = out_node_reg;
        out_nbr_next   = out_nbr_reg;
        out_src_next   = out_src_reg;
        out_snk_next   = out_snk_reg;
        out_ew_next    = out_ew_reg;
        out_last_next  = out_last_reg;

        // Restoring division of the center index by the frame width after a width change.
        if (div_cnt_reg != '0)
        begin
            rem_next     = qbit ? (trial - (DIM_W + 1)'(w_eff)) : trial;
            quo_next     = {quo_reg[CNT_W-2:0], qbit};
            div_cnt_next = div_cnt_reg - DIVC_W'(1);
            if (div_cnt_reg == DIVC_W'(1))
            begin
                col_next = rem_next[DIM_W-1:0];
                row_next = quo_next;
            end
        end
        if (cfg_wr_en && (cfg_index == REG_FRAME_WIDTH))
        begin
            div_cnt_next = DIVC_W'(CNT_W);
            rem_next     = '0;
            quo_next     = c_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pix_stream.valid && in_ready)
                begin
                    has_new_next = acc_has_new;
                    ready_next   = acc_ready;
                    pix_next     = pix_stream.pixel;
                    state_next   = acc_ready ? S_CRD : S_FIN;
                end
            end
            S_CRD:
            begin
                mask_next  = mask_comb;
                state_next = S_CLAT;
            end
            S_CLAT:
            begin
                cv_next    = (has_new_reg && (c_reg == rc_reg)) ? pix_reg : rd_data;
                unary_next = 1'b1;
                last_next  = (mask_reg == '0);
                state_next = S_EMIT;
            end
            S_NEXT:
            begin
                if (mask_reg[k_reg])
                begin
                    ni_next    = ni;
                    fwd_next   = has_new_reg && (ni == rc_reg);
                    last_next  = ((mask_reg >> k_reg) == 8'd1);
                    unary_next = 1'b0;
                    state_next = S_NLAT;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_NLAT:
            begin
                sq_next    = {{PIXEL_W{1'b0}}, d} * {{PIXEL_W{1'b0}}, d};
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(sq_reg) * PROD_W'(smooth_gain_reg);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = ID_W'(c_reg);
                    out_last_next  = last_reg;
                    if (unary_reg)
                    begin
                        out_kind_next = KIND_UNARY;
                        out_nbr_next  = '0;
                        out_src_next  = $signed({1'b0, full_scale_reg})
                                      - $signed({1'b0, cv_reg});
                        out_snk_next  = cv_reg;
                        out_ew_next   = '0;
                        k_next        = 3'd0;
                    end
                    else
                    begin
                        out_kind_next = KIND_EDGE;
                        out_nbr_next  = ID_W'(ni_reg);
                        out_src_next  = '0;
                        out_snk_next  = '0;
                        out_ew_next   = ew_clamped;
                        k_next        = k_reg + 3'd1;
                    end
                    state_next = last_reg ? S_FIN : S_NEXT;
                end
            end
            S_FIN:
            begin
                if (has_new_reg)
                begin
                    rc_next    = rc_reg + CNT_W'(1);
                    wslot_next = (wslot_inc == (SLOT_W + 1)'(STORE_DEPTH)) ? '0
                                                                          : wslot_inc[SLOT_W-1:0];
                end
                if (ready_reg)
                begin
                    c_next     = c_reg + CNT_W'(1);
                    cslot_next = (cslot_inc == (SLOT_W + 1)'(STORE_DEPTH)) ? '0
                                                                          : cslot_inc[SLOT_W-1:0];
                    if (col_inc >= (DIM_W + 1)'(w_eff))
                    begin
                        col_next = '0;
                        row_next = row_reg + CNT_W'(1);
                    end
                    else
                    begin
                        col_next = col_inc[DIM_W-1:0];
                    end
                end
                if (CMP_W'(c_reg) + CMP_W'(ready_reg) >= CMP_W'(total))
                begin
                    rc_next    = '0;
                    c_next     = '0;
                    wslot_next = '0;
                    cslot_next = '0;
                    col_next   = '0;
                    row_next   = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(3);
            frame_height_reg <= DIM_W'(3);
            full_scale_reg   <= PIXEL_W'(255);
            trunc_limit_reg  <= EW_W'(5);
            smooth_gain_reg  <= GAIN_W'(16);
            state_reg        <= S_IDLE;
            rc_reg           <= '0;
            c_reg            <= '0;
            wslot_reg        <= '0;
            cslot_reg        <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            has_new_reg      <= 1'b0;
            ready_reg        <= 1'b0;
            k_reg            <= '0;
            mask_reg         <= '0;
            last_reg         <= 1'b0;
            unary_reg        <= 1'b0;
            fwd_reg          <= 1'b0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:      frame_width_reg  <= cfg_wdata[DIM_W-1:0];
                    REG_FRAME_HEIGHT:     frame_height_reg <= cfg_wdata[DIM_W-1:0];
                    REG_FULL_SCALE:       full_scale_reg   <= cfg_wdata[PIXEL_W-1:0];
                    REG_TRUNCATION_LIMIT: trunc_limit_reg  <= cfg_wdata[EW_W-1:0];
                    REG_SMOOTH_GAIN:      smooth_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg     <= state_next;
            rc_reg        <= rc_next;
            c_reg         <= c_next;
            wslot_reg     <= wslot_next;
            cslot_reg     <= cslot_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            has_new_reg   <= has_new_next;
            ready_reg     <= ready_next;
            k_reg         <= k_next;
            mask_reg      <= mask_next;
            last_reg      <= last_next;
            unary_reg     <= unary_next;
            fwd_reg       <= fwd_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        cv_reg       <= cv_next;
        ni_reg       <= ni_next;
        sq_reg       <= sq_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_kind_reg <= out_kind_next;
        out_node_reg <= out_node_next;
        out_nbr_reg  <= out_nbr_next;
        out_src_reg  <= out_src_next;
        out_snk_reg  <= out_snk_next;
        out_ew_reg   <= out_ew_next;
        out_last_reg <= out_last_next;
    end

    assign pix_stream.ready           = in_ready;
    assign term_stream.valid          = out_valid_reg;
    assign term_stream.kind           = out_kind_reg;
    assign term_stream.node_id        = out_node_reg;
    assign term_stream.neighbour_id   = out_nbr_reg;
    assign term_stream.source_weight  = out_src_reg;
    assign term_stream.sink_weight    = out_snk_reg;
    assign term_stream.edge_weight    = out_ew_reg;
    assign term_stream.last_of_center = out_last_reg;

    // The centre never overtakes the pixels received in the current frame.
    assert property (@(posedge clk) disable iff (!rst_n) c_reg <= rc_reg)
        else $error("center index ahead of received count");

    // Both ring slots stay inside the window store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(wslot_reg) < STORE_DEPTH) && (32'(cslot_reg) < STORE_DEPTH))
        else $error("ring slot outside window store");

    // Outside a width recomputation the tracked column lies inside the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg == '0) |-> (col_reg < w_eff))
        else $error("tracked column beyond frame width");

    // No transaction is taken while the column and row are being recomputed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> !(pix_stream.valid && pix_stream.ready))
        else $error("input taken during width recomputation");

endmodule

`default_nettype wire

// File: tb/graph_cut_energy_terms_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph_cut_energy_terms: directed table, then random frames.

module graph_cut_energy_terms_tb;
    import gcet_pkg::*;

    localparam int FRAME_MAX      = 256;
    localparam int RING_DEPTH     = 2 * FRAME_MAX + 2;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 255;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic         kind;
        node_id_t     node_id;
        node_id_t     neighbour_id;
        src_weight_t  source_weight;
        pixel_t       sink_weight;
        edge_weight_t edge_weight;
        logic         last_of_center;
    } energy_term_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_ITEM_NONE, ROW_ITEM_ONE} row_kind_e;

    typedef struct {
        row_kind_e    kind;
        int unsigned  sel;
        int unsigned  value;
        energy_term_t term;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    gcet_pixel_if pix_if ();
    gcet_term_if  term_if ();

    graph_cut_energy_terms dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_stream  (pix_if),
        .term_stream (term_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    dim_t              cfg_width;
    dim_t              cfg_height;
    pixel_t            cfg_full_scale;
    edge_weight_t      cfg_trunc_limit;
    logic [GAIN_W-1:0] cfg_gain;

    pixel_t      ring_pixels [RING_DEPTH];
    int unsigned pixels_received;
    int unsigned next_center;

    energy_term_t pending_terms[$];
    int unsigned  mismatch_count;
    int unsigned  items_sent;
    int unsigned  terms_seen;
    int unsigned  writes_done;
    int unsigned  frames_done;
    int unsigned  useful_items;
    int unsigned  quiet_cycles;
    bit           steady_flow;
    pixel_t       last_pixel;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input dim_t v);
        if (v == 0) return 1;
        if (v > FRAME_MAX) return FRAME_MAX;
        return v;
    endfunction

    function automatic energy_term_t make_term(input logic kind, input int unsigned node,
                                               input int unsigned nbr, input int src,
                                               input int unsigned sink, input int unsigned ew,
                                               input logic last);
        energy_term_t t;
        t.kind           = kind;
        t.node_id        = node_id_t'(node);
        t.neighbour_id   = node_id_t'(nbr);
        t.source_weight  = src_weight_t'(src);
        t.sink_weight    = pixel_t'(sink);
        t.edge_weight    = edge_weight_t'(ew);
        t.last_of_center = last;
        return t;
    endfunction

    function automatic string describe(input energy_term_t t);
        return $sformatf("kind=%0d node=%0d nbr=%0d src=%0d sink=%0d edge=%0d last=%0d",
                         t.kind, t.node_id, t.neighbour_id, t.source_weight,
                         t.sink_weight, t.edge_weight, t.last_of_center);
    endfunction

    function automatic stim_row_t stim_row(input row_kind_e kind, input int unsigned sel,
                                           input int unsigned value, input energy_term_t term);
        stim_row_t r;
        r.kind  = kind;
        r.sel   = sel;
        r.value = value;
        r.term  = term;
        return r;
    endfunction

    function automatic int unsigned window_pixel(input int unsigned idx, input bit has_new,
                                                 input pixel_t pix);
        if (has_new && idx == pixels_received) return pix;
        return ring_pixels[idx % RING_DEPTH];
    endfunction

    // Works out the terms released by one accepted transaction and advances the shadow state.
    function automatic void predict_terms(input logic mode, input pixel_t pix,
                                          ref energy_term_t terms[$]);
        int unsigned w, h, total, avail, c, cx, cy, ni, nv, cv, d, ew;
        int          ny, nx, dy, dx;
        bit          has_new, ready;
        w       = clamp_dim(cfg_width);
        h       = clamp_dim(cfg_height);
        total   = w * h;
        has_new = (mode == MODE_PIXEL) && (pixels_received < total);
        avail   = pixels_received + (has_new ? 1 : 0);
        c       = next_center;
        ready   = (c < total) && (avail >= total || avail > c + w + 1);
        if (ready) begin
            cx = c % w;
            cy = c / w;
            cv = window_pixel(c, has_new, pix);
            terms.push_back(make_term(KIND_UNARY, c, 0, int'(cfg_full_scale) - int'(cv),
                                      cv, 0, 1'b0));
            for (dy = -1; dy <= 1; dy++) begin
                for (dx = -1; dx <= 1; dx++) begin
                    ny = int'(cy) + dy;
                    nx = int'(cx) + dx;
                    if ((dy != 0 || dx != 0) && ny >= 0 && ny < int'(h)
                        && nx >= 0 && nx < int'(w)) begin
                        ni = unsigned'(ny) * w + unsigned'(nx);
                        nv = window_pixel(ni, has_new, pix);
                        d  = (nv > cv) ? nv - cv : cv - nv;
                        ew = (cfg_gain * d * d) >> 4;
                        if (ew > cfg_trunc_limit) ew = cfg_trunc_limit;
                        terms.push_back(make_term(KIND_EDGE, c, ni, 0, 0, ew, 1'b0));
                    end
                end
            end
            terms[terms.size() - 1].last_of_center = 1'b1;
        end
        if (has_new) ring_pixels[pixels_received % RING_DEPTH] = pix;
        pixels_received = avail;
        if (ready) next_center = c + 1;
        if (next_center >= total) begin
            next_center     = 0;
            pixels_received = 0;
        end
    endfunction

    function automatic pixel_t next_pixel();
        int p;
        case ($urandom_range(9))
            0: p = 0;
            1: p = 255;
            2, 3, 4, 5: p = int'(last_pixel) + int'($urandom_range(6)) - 3;
            default: p = $urandom_range(255);
        endcase
        if (p < 0) p = 0;
        if (p > 255) p = 255;
        last_pixel = pixel_t'(p);
        return last_pixel;
    endfunction

    function automatic int unsigned pick_value(input int unsigned top);
        case ($urandom_range(3))
            0: return 0;
            1: return top;
            default: return $urandom_range(top);
        endcase
    endfunction

    function automatic int unsigned pick_dim(input int unsigned top);
        if ($urandom_range(9) == 0) return 0;
        return $urandom_range(top, 1);
    endfunction

    task automatic wait_for_drain(input bit settle);
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (pending_terms.size() != 0);
        if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:      cfg_width       = value[DIM_W-1:0];
            REG_FRAME_HEIGHT:     cfg_height      = value[DIM_W-1:0];
            REG_FULL_SCALE:       cfg_full_scale  = value[PIXEL_W-1:0];
            REG_TRUNCATION_LIMIT: cfg_trunc_limit = value[EW_W-1:0];
            REG_SMOOTH_GAIN:      cfg_gain        = value[GAIN_W-1:0];
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic send_item(input logic mode, input pixel_t pix);
        if (!steady_flow && $urandom_range(99) < 30) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.mode  <= mode;
        pix_if.pixel <= pix;
        do @(posedge clk); while (!pix_if.ready);
        items_sent++;
    endtask

    task automatic send_and_predict(input logic mode, input pixel_t pix);
        send_item(mode, pix);
        predict_terms(mode, pix, pending_terms);
    endtask

    task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg);
        int unsigned total, k;
        wait_for_drain(1'b1);
        write_register(REG_FRAME_WIDTH, w_reg);
        write_register(REG_FRAME_HEIGHT, h_reg);
        write_register(REG_FULL_SCALE, pick_value(255));
        write_register(REG_TRUNCATION_LIMIT,
                       $urandom_range(1) ? pick_value(65535) : $urandom_range(400));
        write_register(REG_SMOOTH_GAIN, pick_value(255));
        total = clamp_dim(cfg_width) * clamp_dim(cfg_height);
        for (k = 0; k < total; k++) begin
            if ($urandom_range(99) < 5) wait_for_drain(1'b0);
            if ($urandom_range(99) < 8) send_and_predict(MODE_DRAIN, pixel_t'($urandom_range(255)));
            send_and_predict(MODE_PIXEL, next_pixel());
            useful_items++;
        end
        while (pixels_received != 0) begin
            if ($urandom_range(99) < 20) send_and_predict(MODE_PIXEL, next_pixel());
            else send_and_predict(MODE_DRAIN, pixel_t'($urandom_range(255)));
            useful_items++;
        end
        frames_done++;
    endtask

    initial begin
        term_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            term_if.ready <= steady_flow || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk) begin
        energy_term_t got, want;
        if (rst_n && term_if.valid && term_if.ready) begin
            got.kind           = term_if.kind;
            got.node_id        = term_if.node_id;
            got.neighbour_id   = term_if.neighbour_id;
            got.source_weight  = term_if.source_weight;
            got.sink_weight    = term_if.sink_weight;
            got.edge_weight    = term_if.edge_weight;
            got.last_of_center = term_if.last_of_center;
            terms_seen++;
            if (pending_terms.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected term %s", $time, describe(got));
            end else begin
                want = pending_terms.pop_front();
                if (got.kind !== want.kind || got.node_id !== want.node_id
                    || got.neighbour_id !== want.neighbour_id
                    || got.source_weight !== want.source_weight
                    || got.sink_weight !== want.sink_weight
                    || got.edge_weight !== want.edge_weight
                    || got.last_of_center !== want.last_of_center) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: term mismatch\n  expected %s\n  actual   %s",
                                 $time, describe(want), describe(got));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (term_if.valid && term_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d terms outstanding", pending_terms.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        stim_row_t    directed_rows[$];
        stim_row_t    r;
        energy_term_t scratch[$];
        energy_term_t no_term;
        bit           in_writes;
        int unsigned  phase;

        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_FRAME_WIDTH;
        cfg_wdata    <= '0;
        pix_if.valid <= 1'b0;
        pix_if.mode  <= MODE_PIXEL;
        pix_if.pixel <= '0;
        quiet_cycles = 0;
        cfg_width       = 9'd3;
        cfg_height      = 9'd3;
        cfg_full_scale  = 8'd255;
        cfg_trunc_limit = 16'd5;
        cfg_gain        = 8'd16;
        pixels_received = 0;
        next_center     = 0;
        last_pixel      = 8'd128;
        steady_flow     = 1'b0;
        in_writes       = 1'b0;
        no_term = make_term(KIND_UNARY, 0, 0, 0, 0, 0, 1'b0);

        // Reset geometry 3x3: early drain, a full frame, an extra pixel, then the flush.
        directed_rows.push_back(stim_row(ROW_ITEM_NONE, MODE_DRAIN, 0, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 0, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 255, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 128, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 1, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 254, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 127, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 64, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 200, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 3, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 77, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_DRAIN, 0, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_DRAIN, 0, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_DRAIN, 0, no_term));
        // Two rows of a frame, then a shrink to 1x1 that rewinds the counters.
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 10, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 11, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 250, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 12, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 13, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 9, no_term));
        directed_rows.push_back(stim_row(ROW_WRITE, REG_FRAME_WIDTH, 0, no_term));
        directed_rows.push_back(stim_row(ROW_WRITE, REG_FRAME_HEIGHT, 0, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM_NONE, MODE_PIXEL, 9, no_term));
        // Single pixel frames with the weight extremes.
        directed_rows.push_back(stim_row(ROW_WRITE, REG_FULL_SCALE, 0, no_term));
        directed_rows.push_back(stim_row(ROW_WRITE, REG_TRUNCATION_LIMIT, 65535, no_term));
        directed_rows.push_back(stim_row(ROW_WRITE, REG_SMOOTH_GAIN, 255, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM_ONE, MODE_PIXEL, 200,
                                         make_term(KIND_UNARY, 0, 0, -200, 200, 0, 1'b1)));
        directed_rows.push_back(stim_row(ROW_ITEM_ONE, MODE_PIXEL, 255,
                                         make_term(KIND_UNARY, 0, 0, -255, 255, 0, 1'b1)));
        // Two pixel row with the largest difference.
        directed_rows.push_back(stim_row(ROW_WRITE, REG_FRAME_WIDTH, 2, no_term));
        directed_rows.push_back(stim_row(ROW_WRITE, REG_FRAME_HEIGHT, 1, no_term));
        directed_rows.push_back(stim_row(ROW_WRITE, REG_FULL_SCALE, 255, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 0, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_PIXEL, 255, no_term));
        directed_rows.push_back(stim_row(ROW_ITEM, MODE_DRAIN, 0, no_term));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.kind == ROW_WRITE) begin
                if (!in_writes) wait_for_drain(1'b1);
                write_register(r.sel[CFG_IDX_W-1:0], r.value);
                in_writes = 1'b1;
            end else begin
                send_item(r.sel[0], r.value[PIXEL_W-1:0]);
                scratch.delete();
                predict_terms(r.sel[0], r.value[PIXEL_W-1:0], scratch);
                case (r.kind)
                    ROW_ITEM:     foreach (scratch[j]) pending_terms.push_back(scratch[j]);
                    ROW_ITEM_ONE: pending_terms.push_back(r.term);
                    default: ;
                endcase
                in_writes = 1'b0;
            end
        end

        phase = 0;
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            steady_flow = (phase >= 3 && phase <= 6);
            run_frame(pick_dim(9), pick_dim(6));
            phase++;
        end
        steady_flow = 1'b0;
        run_frame(511, 2);
        run_frame(1, 300);

        wait_for_drain(1'b1);
        $display("Run covered %0d input transactions and %0d energy terms over %0d frames.",
                 items_sent, terms_seen, frames_done);
        $display("Geometries from 1x1 to 256 wide and 256 tall, %0d register writes.",
                 writes_done);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
